FILE: design/ibr_pkg.sv
package ibr_pkg;

  localparam int unsigned FIFO_DEPTH   = 32;
  localparam int unsigned CREDIT_WIDTH = 16;
  localparam int unsigned LEVEL_WIDTH  = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned IN_DATA_WIDTH  = 104;
  localparam int unsigned IN_USER_WIDTH  = 2;
  localparam int unsigned OUT_DATA_WIDTH = 56;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CREDIT = 2'd2
  } op_e;

  localparam logic [7:0] OFF_CTRL  = 8'd0;
  localparam logic [7:0] OFF_MODE  = 8'd4;
  localparam logic [7:0] OFF_PRESC = 8'd8;
  localparam logic [7:0] OFF_FCTRL = 8'd12;
  localparam logic [7:0] OFF_FIFO  = 8'd16;

  typedef logic [CREDIT_WIDTH-1:0] credit_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  reg_offset;
    logic [31:0] write_value;
    logic [31:0] codec_sample;
    logic [15:0] tx_space;
    logic [15:0] rx_avail;
  } item_t;

  typedef struct packed {
    logic        bad_register;
    logic        rx_dma_request;
    logic        tx_dma_request;
    logic        codec_sample_taken;
    logic [31:0] codec_out_word;
    logic        codec_out_valid;
    logic [15:0] read_value;
  } result_t;

endpackage

FILE: design/ibr_core.sv
module ibr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ibr_pkg::item_t   item_i,
  output ibr_pkg::result_t result_o
);
  import ibr_pkg::*;

  localparam logic [CREDIT_WIDTH-1:0] DepthCredit = CREDIT_WIDTH'(FIFO_DEPTH);
  localparam logic [CREDIT_WIDTH-1:0] CreditMax   = {CREDIT_WIDTH{1'b1}};

  logic [5:0]  ctrl_q, ctrl_d;
  logic [8:0]  mode_q, mode_d;
  logic [9:0]  presc_q, presc_d;
  logic [3:0]  fctrl_q, fctrl_d;
  credit_t     tx_q, tx_d;
  credit_t     rx_q, rx_d;
  logic        phase_q, phase_d;
  logic [15:0] held_q, held_d;

  logic        tx_en_q, rx_en_q, rx_rdy_q;
  logic        tx_en_d, rx_en_d, tx_rdy_d, rx_rdy_d;
  logic [LEVEL_WIDTH-1:0] room, fill;
  credit_t     tx_new, rx_new;
  result_t     res;

  assign tx_en_q  = ctrl_q[0] & ~ctrl_q[3] & mode_q[7] & fctrl_q[1];
  assign rx_en_q  = ctrl_q[0] & ~ctrl_q[2] & mode_q[6] & fctrl_q[0];
  assign rx_rdy_q = rx_en_q & (rx_q != '0);

  assign room = (tx_q < DepthCredit) ? LEVEL_WIDTH'(DepthCredit - tx_q) : '0;
  assign fill = (rx_q < DepthCredit) ? LEVEL_WIDTH'(rx_q) : LEVEL_WIDTH'(FIFO_DEPTH);

  // credits saturate at the credit width
  assign tx_new = (32'(item_i.tx_space) > 32'(CreditMax)) ? CreditMax
                                                          : CREDIT_WIDTH'(item_i.tx_space);
  assign rx_new = (32'(item_i.rx_avail) > 32'(CreditMax)) ? CreditMax
                                                          : CREDIT_WIDTH'(item_i.rx_avail);

  always_comb begin
    ctrl_d  = ctrl_q;
    mode_d  = mode_q;
    presc_d = presc_q;
    fctrl_d = fctrl_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    phase_d = phase_q;
    held_d  = held_q;
    res     = '0;
    case (item_i.op)
      OP_READ: begin
        unique case (item_i.reg_offset)
          OFF_CTRL:  res.read_value = {7'd0, 1'b1, 1'b1, rx_rdy_q, ctrl_q};
          OFF_MODE:  res.read_value = {7'd0, mode_q};
          OFF_PRESC: res.read_value = {6'd0, presc_q};
          OFF_FCTRL: res.read_value = {fctrl_q, 12'(room) << 6} | 16'(fill);
          OFF_FIFO: begin
            if (rx_q != '0) begin
              rx_d    = rx_q - 1'b1;
              phase_d = ~phase_q;
              if (!phase_q) begin
                held_d                 = item_i.codec_sample[15:0];
                res.read_value         = item_i.codec_sample[31:16];
                res.codec_sample_taken = 1'b1;
              end else begin
                res.read_value = held_q;
              end
            end else begin
              res.bad_register = 1'b1;
            end
          end
          default: res.bad_register = 1'b1;
        endcase
      end
      OP_WRITE: begin
        unique case (item_i.reg_offset)
          OFF_CTRL:  ctrl_d  = item_i.write_value[5:0];
          OFF_MODE:  mode_d  = item_i.write_value[8:0];
          OFF_PRESC: presc_d = item_i.write_value[9:0];
          OFF_FCTRL: fctrl_d = item_i.write_value[15:12];
          OFF_FIFO: begin
            if ((tx_q != '0) && tx_en_q) begin
              tx_d    = tx_q - 1'b1;
              phase_d = ~phase_q;
              if (phase_q) begin
                res.codec_out_valid = 1'b1;
                res.codec_out_word  = {held_q, item_i.write_value[15:0]};
              end else begin
                held_d = item_i.write_value[15:0];
              end
            end
          end
          default: res.bad_register = 1'b1;
        endcase
      end
      OP_CREDIT: begin
        tx_d = tx_new;
        rx_d = rx_new;
      end
      default: ;
    endcase

    tx_en_d  = ctrl_d[0] & ~ctrl_d[3] & mode_d[7] & fctrl_d[1];
    rx_en_d  = ctrl_d[0] & ~ctrl_d[2] & mode_d[6] & fctrl_d[0];
    tx_rdy_d = tx_en_d & (tx_d != '0);
    rx_rdy_d = rx_en_d & (rx_d != '0);
    res.tx_dma_request = ctrl_d[5] & tx_rdy_d & fctrl_d[3];
    res.rx_dma_request = ctrl_d[4] & rx_rdy_d & fctrl_d[2];
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      mode_q  <= '0;
      presc_q <= '0;
      fctrl_q <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      phase_q <= 1'b0;
      held_q  <= '0;
    end else if (fire_i) begin
      ctrl_q  <= ctrl_d;
      mode_q  <= mode_d;
      presc_q <= presc_d;
      fctrl_q <= fctrl_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pack_on_odd_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.codec_out_valid |-> phase_q)
    else $error("packed word emitted on even half");

  a_fifo_read_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.op == OP_READ && item_i.reg_offset == OFF_FIFO && rx_q != '0)
    |=> (phase_q != $past(phase_q)) && (rx_q == $past(rx_q) - 1'b1))
    else $error("fifo read did not advance phase and credit");
`endif

endmodule

FILE: design/i2s_bus_interface_registers.sv
// i2s controller register block on stream channels
// slave channel: one transaction per bus access or codec credit update;
//   tuser carries the access kind (0 read, 1 write, 2 credit update),
//   tdata carries offset, write data, codec sample and the two credits
// master channel: exactly one result transaction per accepted item with
//   read data, packed codec word, sample-taken flag, dma levels and the
//   bad-register flag
// results pass through an input register and a result register with the
//   register logic between
// throughput: one item per cycle while the master takes results; state is updated
//   as an item moves from input register into result register, so the next item sees it
// a stalled master holds the result; one more item waits in the input
//   register and the slave channel then deasserts tready
// reset: both registers empty; control reads back 0x180 and fifo control 0x800 (free room);
//   all other registers, credits, the half-word phase and the held half are zero
module i2s_bus_interface_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // offset[7:0], write_value[39:8], codec_sample[71:40], tx_space[87:72],
  // rx_avail[103:88]
  input  logic [ibr_pkg::IN_DATA_WIDTH-1:0] s_axis_tdata_i,
  // op[1:0]
  input  logic [ibr_pkg::IN_USER_WIDTH-1:0] s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[15:0], codec_out_valid[16], codec_out_word[48:17],
  // codec_sample_taken[49], tx_dma_request[50], rx_dma_request[51],
  // bad_register[52], zero[55:53]
  output logic [ibr_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata_o
);
  import ibr_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res;
  logic    advance;
  logic    in_fire;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  ibr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (item_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{op:           s_axis_tuser_i,
                  reg_offset:   s_axis_tdata_i[7:0],
                  write_value:  s_axis_tdata_i[39:8],
                  codec_sample: s_axis_tdata_i[71:40],
                  tx_space:     s_axis_tdata_i[87:72],
                  rx_avail:     s_axis_tdata_i[103:88]};
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, res_q};

`ifndef NO_ASSERTIONS
  a_pack_excl_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res_q.codec_out_valid && res_q.codec_sample_taken))
    else $error("codec word and sample take in one result");

  a_bad_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_q.bad_register)
    |-> (res_q.read_value == '0) && !res_q.codec_out_valid && !res_q.codec_sample_taken)
    else $error("bad register result carries data");

  a_pack_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_q.codec_out_valid) |-> (res_q.read_value == '0))
    else $error("codec word with read data");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(item_q))
    else $error("waiting item lost");
`endif

endmodule

FILE: tb/sv/i2s_bus_interface_registers_tb.sv
module i2s_bus_interface_registers_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibr_pkg::*;

  localparam logic [7:0] OFF_BAD_TOP       = 8'hff;
  localparam logic [7:0] OFF_BAD_UNALIGNED = 8'h03;
  localparam logic [7:0] REG_OFFSETS [4]   = '{OFF_CTRL, OFF_MODE, OFF_PRESC, OFF_FCTRL};
  localparam int unsigned ITEMS_PER_PHASE  = 480;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_DATA_WIDTH-1:0] s_data = '0;
  logic [IN_USER_WIDTH-1:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  result_t pending_responses[$];

  // predicted register state
  logic [8:0]  ctrl_q;
  logic [8:0]  mode_q;
  logic [9:0]  presc_q;
  logic [15:0] fctrl_q;
  credit_t     tx_credit_q;
  credit_t     rx_credit_q;
  logic        phase_q;
  logic [15:0] held_q;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  i2s_bus_interface_registers i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  function automatic logic tx_enabled();
    return ctrl_q[0] && !ctrl_q[3] && mode_q[7] && fctrl_q[13];
  endfunction

  function automatic logic rx_enabled();
    return ctrl_q[0] && !ctrl_q[2] && mode_q[6] && fctrl_q[12];
  endfunction

  // ready bits 7 and 6 always follow enables and credits
  function automatic logic [8:0] control_value();
    return {ctrl_q[8], tx_enabled() && tx_credit_q != 0,
            rx_enabled() && rx_credit_q != 0, ctrl_q[5:0]};
  endfunction

  function automatic void reset_predictor();
    ctrl_q      = 9'h100;
    mode_q      = '0;
    presc_q     = '0;
    fctrl_q     = '0;
    tx_credit_q = '0;
    rx_credit_q = '0;
    phase_q     = 1'b0;
    held_q      = '0;
  endfunction

  function automatic result_t predict_access(item_t it);
    result_t r;
    logic [8:0] ctrl_v;
    int unsigned room;
    int unsigned fill;
    r = '0;
    case (op_e'(it.op))
      OP_READ: begin
        case (it.reg_offset)
          OFF_CTRL:  r.read_value = 16'(control_value() | 9'h080);
          OFF_MODE:  r.read_value = 16'(mode_q);
          OFF_PRESC: r.read_value = 16'(presc_q);
          OFF_FCTRL: begin
            room = (tx_credit_q < FIFO_DEPTH) ? FIFO_DEPTH - tx_credit_q : 0;
            fill = (rx_credit_q < FIFO_DEPTH) ? rx_credit_q : FIFO_DEPTH;
            r.read_value = fctrl_q | 16'(room << 6) | 16'(fill);
          end
          OFF_FIFO: begin
            if (rx_credit_q != 0) begin
              rx_credit_q = rx_credit_q - 1'b1;
              phase_q = !phase_q;
              if (phase_q) begin
                held_q = it.codec_sample[15:0];
                r.read_value = it.codec_sample[31:16];
                r.codec_sample_taken = 1'b1;
              end else begin
                r.read_value = held_q;
              end
            end else begin
              r.bad_register = 1'b1;
            end
          end
          default: r.bad_register = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (it.reg_offset)
          OFF_CTRL:  ctrl_q = {ctrl_q[8], 2'b00, it.write_value[5:0]};
          OFF_MODE:  mode_q = it.write_value[8:0];
          OFF_PRESC: presc_q = it.write_value[9:0];
          OFF_FCTRL: fctrl_q = {it.write_value[15:12], 12'h000};
          OFF_FIFO: begin
            if (tx_credit_q != 0 && tx_enabled()) begin
              tx_credit_q = tx_credit_q - 1'b1;
              if (phase_q) begin
                r.codec_out_valid = 1'b1;
                r.codec_out_word  = {held_q, it.write_value[15:0]};
              end else begin
                held_q = it.write_value[15:0];
              end
              phase_q = !phase_q;
            end
          end
          default: r.bad_register = 1'b1;
        endcase
      end
      OP_CREDIT: begin
        tx_credit_q = it.tx_space;
        rx_credit_q = it.rx_avail;
      end
      default: ;
    endcase
    ctrl_v = control_value();
    r.tx_dma_request = ctrl_v[5] & ctrl_v[7] & fctrl_q[15];
    r.rx_dma_request = ctrl_v[4] & ctrl_v[6] & fctrl_q[14];
    return r;
  endfunction

  function automatic item_t access(logic [1:0] op, logic [7:0] offset, logic [31:0] wv,
                                   logic [31:0] sample, logic [15:0] txs, logic [15:0] rxa);
    item_t it;
    it.op           = op;
    it.reg_offset   = offset;
    it.write_value  = wv;
    it.codec_sample = sample;
    it.tx_space     = txs;
    it.rx_avail     = rxa;
    return it;
  endfunction

  function automatic credit_t random_credit();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 7) return credit_t'($urandom_range(40));
    if (pick == 7) return '1;
    return credit_t'($urandom);
  endfunction

  // mostly enabling register values and fifo traffic, some noise
  function automatic item_t random_access();
    item_t it;
    int unsigned pick;
    it = access(OP_READ, 8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.op = OP_CREDIT;
      it.tx_space = random_credit();
      it.rx_avail = random_credit();
    end else if (pick < 15) begin
      it.op = op_e'($urandom_range(2));
    end else if (pick < 30) begin
      it.op = OP_WRITE;
      it.reg_offset = REG_OFFSETS[$urandom_range(3)];
      case (it.reg_offset)
        OFF_CTRL: begin
          if ($urandom_range(3) != 0) begin
            it.write_value[0]   = 1'b1;
            it.write_value[3:2] = 2'b00;
          end
        end
        OFF_MODE:  if ($urandom_range(4) != 0) it.write_value[7:6] = 2'b11;
        OFF_FCTRL: if ($urandom_range(4) != 0) it.write_value[15:12] = 4'hf;
        default: ;
      endcase
    end else if (pick < 40) begin
      it.reg_offset = REG_OFFSETS[$urandom_range(3)];
    end else if (pick < 70) begin
      it.op = OP_WRITE;
      it.reg_offset = OFF_FIFO;
    end else begin
      it.reg_offset = OFF_FIFO;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    s_data  <= {it.rx_avail, it.tx_space, it.codec_sample, it.write_value, it.reg_offset};
    s_user  <= it.op;
    s_valid <= 1'b1;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    pending_responses.push_back(predict_access(it));
    if ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_all_responses();
    s_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s at %0t: expected %h, got %h", name, $realtime, want, got);
    end
  endtask

  task automatic check_response(input result_t want, input result_t got);
    check_field("read_value", 32'(want.read_value), 32'(got.read_value));
    check_field("codec_out_valid", 32'(want.codec_out_valid), 32'(got.codec_out_valid));
    check_field("codec_out_word", want.codec_out_word, got.codec_out_word);
    check_field("codec_sample_taken", 32'(want.codec_sample_taken),
                32'(got.codec_sample_taken));
    check_field("tx_dma_request", 32'(want.tx_dma_request), 32'(got.tx_dma_request));
    check_field("rx_dma_request", 32'(want.rx_dma_request), 32'(got.rx_dma_request));
    check_field("bad_register", 32'(want.bad_register), 32'(got.bad_register));
  endtask

  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && m_valid && m_ready) begin
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result at %0t: %h", $realtime, m_data);
      end else begin
        check_response(pending_responses.pop_front(), result_t'(m_data[$bits(result_t)-1:0]));
      end
    end
  end

  task automatic test_reset_values();
    send_item(access(OP_READ, OFF_CTRL, '0, '0, '0, '0));
    send_item(access(OP_READ, OFF_MODE, '0, '0, '0, '0));
    send_item(access(OP_READ, OFF_FCTRL, '0, '0, '0, '0));
    send_item(access(OP_READ, OFF_FIFO, '0, 32'hdead_beef, '0, '0));
    send_item(access(OP_READ, OFF_BAD_TOP, '0, '0, '0, '0));
    send_item(access(OP_WRITE, OFF_BAD_UNALIGNED, '1, '0, '0, '0));
  endtask

  task automatic test_register_masks();
    send_item(access(OP_WRITE, OFF_CTRL, '1, '0, '0, '0));
    send_item(access(OP_WRITE, OFF_MODE, '1, '0, '0, '0));
    send_item(access(OP_WRITE, OFF_PRESC, '1, '0, '0, '0));
    send_item(access(OP_WRITE, OFF_FCTRL, '1, '0, '0, '0));
    send_item(access(OP_READ, OFF_PRESC, '0, '0, '0, '0));
    send_item(access(OP_READ, OFF_FCTRL, '0, '0, '0, '0));
  endtask

  task automatic test_fifo_data();
    send_item(access(OP_WRITE, OFF_CTRL, 32'hffff_ffb1, '0, '0, '0));
    send_item(access(OP_CREDIT, OFF_BAD_TOP, '1, '1, '1, '1));
    send_item(access(OP_WRITE, OFF_FIFO, 32'h1234_ffff, '0, '0, '0));
    send_item(access(OP_WRITE, OFF_FIFO, 32'hffff_0000, '0, '0, '0));
    send_item(access(OP_READ, OFF_FIFO, '0, 32'hffff_0001, '0, '0));
    send_item(access(OP_READ, OFF_FIFO, '0, '0, '0, '0));
    send_item(access(OP_READ, OFF_CTRL, '0, '0, '0, '0));
    send_item(access(OP_CREDIT, OFF_CTRL, '0, '0, 16'd1, '0));
    send_item(access(OP_READ, OFF_FIFO, '0, '1, '0, '0));
    send_item(access(OP_WRITE, OFF_FIFO, 32'h0000_5a5a, '0, '0, '0));
    send_item(access(OP_WRITE, OFF_FIFO, 32'ha5a5_0000, '0, '0, '0));
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_item(random_access());
    wait_all_responses();
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_register_masks();
    test_fifo_data();
    wait_all_responses();
    test_random_traffic(ITEMS_PER_PHASE, 34, 83);
    test_random_traffic(ITEMS_PER_PHASE, 83, 34);
    test_random_traffic(ITEMS_PER_PHASE, 0, 0);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
design/ibr_pkg.sv
design/ibr_core.sv
design/i2s_bus_interface_registers.sv
tb/sv/i2s_bus_interface_registers_tb.sv
